// ----- src/pcm_pkg.sv -----
package pcm_pkg;

  // Field widths of the two channels.
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ID_W  = 32;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned LEN_W = 9;

  // Default sizes of the two lists.
  localparam int unsigned CORRIDOR_DEPTH_DEF = 256;
  localparam int unsigned VISITED_DEPTH_DEF  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_CORRIDOR = 3'd0,
    OP_PUSH_VISITED  = 3'd1,
    OP_MERGE         = 3'd2,
    OP_READ          = 3'd3,
    OP_CLEAR         = 3'd4
  } opcode_e;

  // One corridor word moving down the row of compare cells.
  typedef struct packed {
    logic            live;
    logic            hit;
    logic [ID_W-1:0] word;
  } beat_t;

endpackage

// ----- src/pcm_if.sv -----
interface pcm_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcm_pkg::OP_W-1:0]  opcode;
  logic [pcm_pkg::ID_W-1:0]  poly_id;
  logic [pcm_pkg::IDX_W-1:0] read_index;

  modport source (output valid, opcode, poly_id, read_index, input ready);
  modport sink (input valid, opcode, poly_id, read_index, output ready);
endinterface

interface pcm_out_if;
  logic                      valid;
  logic                      ready;
  logic [pcm_pkg::ID_W-1:0]  element_id;
  logic [pcm_pkg::LEN_W-1:0] corridor_length;
  logic                      merge_found;
  logic                      index_valid;

  modport source (output valid, element_id, corridor_length, merge_found, index_valid,
                  input ready);
  modport sink (input valid, element_id, corridor_length, merge_found, index_valid,
                output ready);
endinterface

// ----- src/path_corridor_merge.sv -----
// Corridor fix-up engine. Beats arrive on in_i (opcode, poly_id, read_index)
// and every defined opcode returns one result beat on out_o; opcodes 5 to 7
// are swallowed without a result.
//
// For push, push-visited and clear the result is registered and appears the
// cycle after the input beat. A read goes through the registered read port of
// the corridor RAM before it reaches the result register. A merge runs as a
// sequence of states: the corridor words are read from the newest down, one
// per cycle, and flow through a row of VISITED_DEPTH compare cells, one cell
// per visited id, until a match leaves the last cell or the row has drained.
// The tail is then moved one word a cycle, the visited ids are written in
// front one a cycle, and the result follows.
//
// Reset clears both list lengths and the output valid flag; the stored ids are
// not cleared and need no clearing pass. While a result waits on a stalled
// receiver, in_i.ready stays low, since the next beat would need the output
// register; nothing is dropped.
module path_corridor_merge #(
  parameter int unsigned CORRIDOR_DEPTH = pcm_pkg::CORRIDOR_DEPTH_DEF,
  parameter int unsigned VISITED_DEPTH  = pcm_pkg::VISITED_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pcm_in_if.sink           in_i,
  pcm_out_if.source        out_o
);

  localparam int unsigned CW  = $clog2(CORRIDOR_DEPTH + 1);
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned AW  = $clog2(CORRIDOR_DEPTH);
  localparam int unsigned VCW = $clog2(VISITED_DEPTH + 1);
  localparam int unsigned VIW = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
  localparam int unsigned RW  = (CW > pcm_pkg::IDX_W) ? CW : pcm_pkg::IDX_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;
  localparam logic [2:0] S_FILL  = 3'd6;

  logic [2:0] state_q, state_d;

  // List lengths.
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [VCW-1:0] vcnt_q, vcnt_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [pcm_pkg::ID_W-1:0]   out_elem_q, out_elem_d;
  logic [pcm_pkg::LEN_W-1:0]  out_len_q, out_len_d;
  logic                       out_found_q, out_found_d;
  logic                       out_ivalid_q, out_ivalid_d;

  // Corridor RAM, one write port and one registered read port.
  logic [pcm_pkg::ID_W-1:0] mem_q [CORRIDOR_DEPTH];
  logic [pcm_pkg::ID_W-1:0] rdata_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [pcm_pkg::ID_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;

  // Read and scan bookkeeping.
  logic          rd_ok_q, rd_ok_d;
  logic          rd_live_q, rd_live_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [VCW-1:0] drain_q, drain_d;

  // Match found by the scan.
  logic [AW-1:0]  ci_q, ci_d;
  logic [VIW-1:0] vj_q, vj_d;

  // Tail move and visited fill.
  logic [VCW-1:0] req_q, req_d;
  logic [CW-1:0]  new_len_q, new_len_d;
  logic [CW-1:0]  mv_rem_q, mv_rem_d;
  logic [AW-1:0]  mv_src_q, mv_src_d;
  logic [AW-1:0]  mv_dst_q, mv_dst_d;
  logic           mv_desc_q, mv_desc_d;
  logic           mv_wen_q, mv_wen_d;
  logic [AW-1:0]  mv_wdst_q, mv_wdst_d;
  logic [VCW-1:0] fill_k_q, fill_k_d;

  // Merge arithmetic, worked out in the cycle after the match.
  logic [CW-1:0]  orig_w;
  logic [CW-1:0]  sfull_w;
  logic [VCW-1:0] req_w;
  logic [CW1-1:0] tot_w;
  logic [CW-1:0]  size_w;

  // Cell row.
  pcm_pkg::beat_t             chain_w [VISITED_DEPTH+1];
  logic [AW-1:0]              cidx_w  [VISITED_DEPTH+1];
  logic [VIW-1:0]             vj_w    [VISITED_DEPTH+1];
  logic [pcm_pkg::ID_W-1:0]   vid_w   [VISITED_DEPTH];
  logic [VISITED_DEPTH-1:0]   cell_wr;
  logic [VISITED_DEPTH-1:0]   cell_en;
  logic                       flush;
  logic                       tail_hit;
  logic                       scanning;
  logic [VIW-1:0]             vid_sel;

  logic in_ready;
  logic in_fire;
  logic out_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign in_fire  = in_i.valid && in_ready;

  assign scanning = (state_q == S_SCAN) || (state_q == S_DRAIN);
  assign tail_hit = scanning && chain_w[VISITED_DEPTH].live && chain_w[VISITED_DEPTH].hit;
  assign flush    = tail_hit ||
                    ((state_q == S_DRAIN) && (drain_q == VCW'(VISITED_DEPTH)));

  // Words leave the RAM read register and enter the first cell.
  assign chain_w[0] = '{live: rd_live_q, hit: 1'b0, word: rdata_q};
  assign cidx_w[0]  = rd_addr_q;
  assign vj_w[0]    = '0;

  for (genvar m = 0; m < VISITED_DEPTH; m++) begin : g_cell
    assign cell_wr[m] = in_fire && (in_i.opcode == pcm_pkg::OP_PUSH_VISITED) &&
                        (vcnt_q == VCW'(m));
    assign cell_en[m] = VCW'(m) < vcnt_q;

    pcm_cell #(
      .AW       (AW),
      .VIW      (VIW),
      .CELL_IDX (m)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flush_i (flush),
      .wr_en_i (cell_wr[m]),
      .wr_id_i (in_i.poly_id),
      .en_i    (cell_en[m]),
      .beat_i  (chain_w[m]),
      .cidx_i  (cidx_w[m]),
      .vj_i    (vj_w[m]),
      .beat_o  (chain_w[m+1]),
      .cidx_o  (cidx_w[m+1]),
      .vj_o    (vj_w[m+1]),
      .id_o    (vid_w[m])
    );
  end

  // The fill writes the visited ids newest first.
  assign vid_sel = VIW'(vcnt_q - VCW'(1) - fill_k_q);

  // Tail placement after a match: the kept tail starts one past the match
  // and lands right behind the visited ids, cut at the corridor depth.
  assign orig_w  = CW'(ci_q) + CW'(1);
  assign sfull_w = cnt_q - orig_w;
  assign req_w   = vcnt_q - VCW'(vj_q);
  assign tot_w   = CW1'(req_w) + CW1'(sfull_w);
  assign size_w  = (tot_w > CW1'(CORRIDOR_DEPTH)) ?
                   CW'(CW1'(CORRIDOR_DEPTH) - CW1'(req_w)) : sfull_w;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    vcnt_d       = vcnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_elem_d   = out_elem_q;
    out_len_d    = out_len_q;
    out_found_d  = out_found_q;
    out_ivalid_d = out_ivalid_q;
    rd_ok_d      = rd_ok_q;
    rd_live_d    = 1'b0;
    rd_addr_d    = rd_addr_q;
    scan_d       = scan_q;
    drain_d      = drain_q;
    ci_d         = ci_q;
    vj_d         = vj_q;
    req_d        = req_q;
    new_len_d    = new_len_q;
    mv_rem_d     = mv_rem_q;
    mv_src_d     = mv_src_q;
    mv_dst_d     = mv_dst_q;
    mv_desc_d    = mv_desc_q;
    mv_wen_d     = 1'b0;
    mv_wdst_d    = mv_wdst_q;
    fill_k_d     = fill_k_q;
    mem_we       = 1'b0;
    mem_waddr    = AW'(cnt_q);
    mem_wdata    = in_i.poly_id;
    mem_raddr    = AW'(in_i.read_index);

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_elem_d   = '0;
          out_found_d  = 1'b0;
          out_ivalid_d = 1'b0;
          case (in_i.opcode)
            pcm_pkg::OP_PUSH_CORRIDOR: begin
              if (cnt_q < CW'(CORRIDOR_DEPTH)) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
              out_len_d   = pcm_pkg::LEN_W'(cnt_d);
              out_valid_d = 1'b1;
            end
            pcm_pkg::OP_PUSH_VISITED: begin
              if (vcnt_q < VCW'(VISITED_DEPTH)) begin
                vcnt_d = vcnt_q + VCW'(1);
              end
              out_len_d   = pcm_pkg::LEN_W'(cnt_q);
              out_valid_d = 1'b1;
            end
            pcm_pkg::OP_MERGE: begin
              if ((cnt_q == '0) || (vcnt_q == '0)) begin
                vcnt_d      = '0;
                out_len_d   = pcm_pkg::LEN_W'(cnt_q);
                out_valid_d = 1'b1;
              end else begin
                scan_d  = AW'(cnt_q - CW'(1));
                state_d = S_SCAN;
              end
            end
            pcm_pkg::OP_READ: begin
              rd_ok_d = RW'(in_i.read_index) < RW'(cnt_q);
              state_d = S_READ;
            end
            pcm_pkg::OP_CLEAR: begin
              cnt_d       = '0;
              out_len_d   = '0;
              out_valid_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        out_elem_d   = rd_ok_q ? rdata_q : '0;
        out_ivalid_d = rd_ok_q;
        out_found_d  = 1'b0;
        out_len_d    = pcm_pkg::LEN_W'(cnt_q);
        out_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end

      S_SCAN: begin
        mem_raddr = scan_q;
        if (tail_hit) begin
          ci_d    = cidx_w[VISITED_DEPTH];
          vj_d    = vj_w[VISITED_DEPTH];
          state_d = S_CALC;
        end else begin
          rd_live_d = 1'b1;
          rd_addr_d = scan_q;
          if (scan_q == '0) begin
            drain_d = '0;
            state_d = S_DRAIN;
          end else begin
            scan_d = scan_q - AW'(1);
          end
        end
      end

      S_DRAIN: begin
        if (tail_hit) begin
          ci_d    = cidx_w[VISITED_DEPTH];
          vj_d    = vj_w[VISITED_DEPTH];
          state_d = S_CALC;
        end else if (drain_q == VCW'(VISITED_DEPTH)) begin
          // No corridor word matched any visited id.
          vcnt_d       = '0;
          out_elem_d   = '0;
          out_ivalid_d = 1'b0;
          out_found_d  = 1'b0;
          out_len_d    = pcm_pkg::LEN_W'(cnt_q);
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          drain_d = drain_q + VCW'(1);
        end
      end

      S_CALC: begin
        req_d     = req_w;
        new_len_d = CW'(req_w) + size_w;
        mv_rem_d  = size_w;
        mv_desc_d = CW'(req_w) > orig_w;
        fill_k_d  = '0;
        if (CW'(req_w) > orig_w) begin
          // Tail moves up: copy from the top end down.
          mv_src_d = AW'(orig_w + size_w - CW'(1));
          mv_dst_d = AW'(CW'(req_w) + size_w - CW'(1));
        end else begin
          mv_src_d = AW'(orig_w);
          mv_dst_d = AW'(req_w);
        end
        state_d = S_MOVE;
      end

      S_MOVE: begin
        mem_raddr = mv_src_q;
        mem_we    = mv_wen_q;
        mem_waddr = mv_wdst_q;
        mem_wdata = rdata_q;
        if (mv_rem_q != '0) begin
          mv_wen_d  = 1'b1;
          mv_wdst_d = mv_dst_q;
          mv_rem_d  = mv_rem_q - CW'(1);
          if (mv_desc_q) begin
            mv_src_d = mv_src_q - AW'(1);
            mv_dst_d = mv_dst_q - AW'(1);
          end else begin
            mv_src_d = mv_src_q + AW'(1);
            mv_dst_d = mv_dst_q + AW'(1);
          end
        end else begin
          state_d = S_FILL;
        end
      end

      S_FILL: begin
        if (fill_k_q != req_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(fill_k_q);
          mem_wdata = vid_w[vid_sel];
          fill_k_d  = fill_k_q + VCW'(1);
        end else begin
          cnt_d        = new_len_q;
          vcnt_d       = '0;
          out_elem_d   = '0;
          out_ivalid_d = 1'b0;
          out_found_d  = 1'b1;
          out_len_d    = pcm_pkg::LEN_W'(new_len_q);
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (flush) begin
      rd_live_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
      rd_live_q   <= 1'b0;
      mv_wen_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      vcnt_q      <= vcnt_d;
      out_valid_q <= out_valid_d;
      rd_live_q   <= rd_live_d;
      mv_wen_q    <= mv_wen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q   <= out_elem_d;
    out_len_q    <= out_len_d;
    out_found_q  <= out_found_d;
    out_ivalid_q <= out_ivalid_d;
    rd_ok_q      <= rd_ok_d;
    rd_addr_q    <= rd_addr_d;
    scan_q       <= scan_d;
    drain_q      <= drain_d;
    ci_q         <= ci_d;
    vj_q         <= vj_d;
    req_q        <= req_d;
    new_len_q    <= new_len_d;
    mv_rem_q     <= mv_rem_d;
    mv_src_q     <= mv_src_d;
    mv_dst_q     <= mv_dst_d;
    mv_desc_q    <= mv_desc_d;
    mv_wdst_q    <= mv_wdst_d;
    fill_k_q     <= fill_k_d;
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.element_id      = out_elem_q;
  assign out_o.corridor_length = out_len_q;
  assign out_o.merge_found     = out_found_q;
  assign out_o.index_valid     = out_ivalid_q;

endmodule

// ----- src/pcm_cell.sv -----
module pcm_cell #(
  parameter int unsigned AW       = 8,
  parameter int unsigned VIW      = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     flush_i,
  input  logic                     wr_en_i,
  input  logic [pcm_pkg::ID_W-1:0] wr_id_i,
  input  logic                     en_i,
  input  pcm_pkg::beat_t           beat_i,
  input  logic [AW-1:0]            cidx_i,
  input  logic [VIW-1:0]           vj_i,
  output pcm_pkg::beat_t           beat_o,
  output logic [AW-1:0]            cidx_o,
  output logic [VIW-1:0]           vj_o,
  output logic [pcm_pkg::ID_W-1:0] id_o
);

  logic [pcm_pkg::ID_W-1:0] id_q;
  logic [pcm_pkg::ID_W-1:0] word_q;
  logic [AW-1:0]            cidx_q;
  logic [VIW-1:0]           vj_q;
  logic                     live_q;
  logic                     hit_q;
  logic                     match;

  // Only the first cell that matches claims the word, so the earliest
  // visited index wins.
  assign match = beat_i.live && !beat_i.hit && en_i && (beat_i.word == id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (flush_i) begin
      live_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      live_q <= beat_i.live;
      hit_q  <= beat_i.hit || match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_q <= wr_id_i;
    end
    word_q <= beat_i.word;
    cidx_q <= cidx_i;
    vj_q   <= match ? VIW'(CELL_IDX) : vj_i;
  end

  assign beat_o = '{live: live_q, hit: hit_q, word: word_q};
  assign cidx_o = cidx_q;
  assign vj_o   = vj_q;
  assign id_o   = id_q;

endmodule

// ----- src/pcm_checker.sv -----
module pcm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [pcm_pkg::ID_W-1:0]  elem_i,
  input logic [pcm_pkg::LEN_W-1:0] len_i,
  input logic                      found_i,
  input logic                      ivalid_i
);

  // A result beat stays up until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A read hit and a merge hit never come from the same beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(found_i && ivalid_i))
    else $error("merge and read flags both set");

  // Only an in-range read carries a nonzero element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ivalid_i |-> elem_i == '0)
    else $error("element without a valid read");

  // A successful merge always leaves at least the matched id in the corridor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> len_i != '0)
    else $error("merge hit with an empty corridor");

  // While a result is stalled, no new input beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("input taken while the output is blocked");

endmodule

bind path_corridor_merge pcm_checker u_pcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .elem_i      (out_o.element_id),
  .len_i       (out_o.corridor_length),
  .found_i     (out_o.merge_found),
  .ivalid_i    (out_o.index_valid)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // The block under test runs at its default list sizes.
  localparam int unsigned CORR_N  = pcm_pkg::CORRIDOR_DEPTH_DEF;
  localparam int unsigned VISIT_N = pcm_pkg::VISITED_DEPTH_DEF;

  // Opcodes 5 to 7 have no name in the package. The block must swallow them
  // without a result beat.
  localparam logic [pcm_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [pcm_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [pcm_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

  // The random part stops after about this many commands that give a result.
  localparam int unsigned CMD_TARGET = 1000;
  // Accepted input beats per idling phase. The phases cycle through: no
  // idling, sender idle, receiver stalling, and both.
  localparam int unsigned PHASE_BEATS = 200;
  // A single long receiver hold-off starts once this many input beats are in.
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  // The longest merge scans the full corridor through the compare row, then
  // moves the tail and writes the visited ids. This comfortably covers that.
  localparam int unsigned DRAIN_CYCLES = 4 * (CORR_N + VISIT_N) + 64;

  typedef struct packed {
    logic [pcm_pkg::OP_W-1:0]  opcode;
    logic [pcm_pkg::ID_W-1:0]  poly_id;
    logic [pcm_pkg::IDX_W-1:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic [pcm_pkg::ID_W-1:0]  element_id;
    logic [pcm_pkg::LEN_W-1:0] corridor_length;
    logic                      merge_found;
    logic                      index_valid;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcm_in_if  cmd_if ();
  pcm_out_if rsp_if ();

  path_corridor_merge #(
    .CORRIDOR_DEPTH(CORR_N),
    .VISITED_DEPTH (VISIT_N)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Commands waiting to be driven, and the replies that the predictor says
  // must come back, oldest first.
  cmd_t   cmd_backlog[$];
  reply_t reply_due[$];

  int unsigned n_cmds;      // generated commands that give a result
  int unsigned n_in;        // accepted input beats
  int unsigned n_fail;
  int unsigned hold_left;
  bit          hold_done;
  logic        in_fire;     // an input beat was accepted at the last rising edge
  cmd_t        drv_cmd;
  cmd_t        seen_cmd;
  reply_t      seen_reply;
  reply_t      want_reply;
  reply_t      made_reply;
  bit          made_any;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the corridor and of the visited list.
  // ---------------------------------------------------------------------------
  logic [pcm_pkg::ID_W-1:0] corr_mem  [CORR_N];
  int unsigned              corr_len;
  logic [pcm_pkg::ID_W-1:0] visit_mem [VISIT_N];
  int unsigned              visit_len;

  // Splices the visited ids into the corridor. The last corridor entry that
  // also occurs among the visited ids is the join point. For that entry the
  // earliest matching visited id is used, so a loop in the visited walk is
  // cut out. Returns whether a join point exists. The visited list is
  // emptied in every case.
  function automatic bit splice_visited();
    logic [pcm_pkg::ID_W-1:0] spliced [CORR_N];
    int   ci;
    int   vj;
    int   head;
    int   tail;
    int   tail_start;
    bit   hit;
    hit = 1'b0;
    ci  = 0;
    vj  = 0;
    for (int i = int'(corr_len) - 1; i >= 0 && !hit; i--) begin
      // Walk the visited list from the newest down so that the earliest
      // match is the one left standing.
      for (int m = int'(visit_len) - 1; m >= 0; m--) begin
        if (corr_mem[i] == visit_mem[m]) begin
          ci  = i;
          vj  = m;
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      head       = int'(visit_len) - vj;
      tail_start = ci + 1;
      tail       = int'(corr_len) - tail_start;
      if (head + tail > int'(CORR_N)) begin
        tail = int'(CORR_N) - head;
      end
      // Build the new corridor apart, since source and target overlap.
      for (int k = 0; k < head; k++) begin
        spliced[k] = visit_mem[int'(visit_len) - 1 - k];
      end
      for (int k = 0; k < tail; k++) begin
        spliced[head + k] = corr_mem[tail_start + k];
      end
      for (int k = 0; k < head + tail; k++) begin
        corr_mem[k] = spliced[k];
      end
      corr_len = head + tail;
    end
    visit_len = 0;
    return hit;
  endfunction

  // Applies one accepted command to the predictor state and works out the
  // reply it must produce. Spare opcodes change nothing and give no reply.
  function automatic void apply_command(input cmd_t c, output bit gives,
                                        output reply_t r);
    r     = '0;
    gives = 1'b1;
    case (c.opcode)
      pcm_pkg::OP_PUSH_CORRIDOR: begin
        // A push to a full corridor is dropped.
        if (corr_len < CORR_N) begin
          corr_mem[corr_len] = c.poly_id;
          corr_len++;
        end
      end
      pcm_pkg::OP_PUSH_VISITED: begin
        if (visit_len < VISIT_N) begin
          visit_mem[visit_len] = c.poly_id;
          visit_len++;
        end
      end
      pcm_pkg::OP_MERGE: begin
        r.merge_found = splice_visited();
      end
      pcm_pkg::OP_READ: begin
        // Out of range reads return zero with index_valid low.
        if (c.read_index < corr_len) begin
          r.element_id  = corr_mem[c.read_index];
          r.index_valid = 1'b1;
        end
      end
      pcm_pkg::OP_CLEAR: begin
        // Only the corridor is emptied; the visited list stays.
        corr_len = 0;
      end
      default: begin
        gives = 1'b0;
      end
    endcase
    r.corridor_length = pcm_pkg::LEN_W'(corr_len);
  endfunction

  function automatic void report(string what);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%0t ns: %s", $time, what);
    end
  endfunction

  function automatic void add_cmd(logic [pcm_pkg::OP_W-1:0] op,
                                  logic [pcm_pkg::ID_W-1:0] id,
                                  logic [pcm_pkg::IDX_W-1:0] idx);
    cmd_t c;
    c.opcode     = op;
    c.poly_id    = id;
    c.read_index = idx;
    cmd_backlog.push_back(c);
    if (op <= pcm_pkg::OP_CLEAR) begin
      n_cmds++;
    end
  endfunction

  // Idling follows the phase, which advances with the accepted input beats.
  function automatic int unsigned idle_phase();
    return (n_in / PHASE_BEATS) % 4;
  endfunction

  function automatic bit sender_rests();
    case (idle_phase())
      1:       return $urandom_range(99) < 68;
      3:       return $urandom_range(99) < 22;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (idle_phase())
      2:       return $urandom_range(99) < 68;
      3:       return $urandom_range(99) < 22;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next command at the falling edge. A beat on the bus
  // stays put until the rising edge at which it is accepted.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || in_fire) begin
      if (cmd_backlog.size() != 0 && !sender_rests()) begin
        drv_cmd = cmd_backlog.pop_front();
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= drv_cmd.opcode;
        cmd_if.poly_id    <= drv_cmd.poly_id;
        cmd_if.read_index <= drv_cmd.read_index;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random, and once for a long stretch so that the
  // result register stays full and the block has to hold its input off.
  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && (hold_left == 0) && !receiver_rests();
  end

  // The long hold-off is counted here. n_in only changes through a
  // nonblocking assignment, so reading it at the rising edge is safe.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, checks a result beat against the oldest
  // expectation, then feeds an accepted command beat to the predictor. A
  // result can never belong to a command accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen_reply.element_id      = rsp_if.element_id;
        seen_reply.corridor_length = rsp_if.corridor_length;
        seen_reply.merge_found     = rsp_if.merge_found;
        seen_reply.index_valid     = rsp_if.index_valid;
        if (reply_due.size() == 0) begin
          report($sformatf("result beat with nothing expected: elem %h len %0d",
                           seen_reply.element_id, seen_reply.corridor_length));
        end else begin
          want_reply = reply_due.pop_front();
          if (seen_reply.element_id !== want_reply.element_id ||
              seen_reply.corridor_length !== want_reply.corridor_length ||
              seen_reply.merge_found !== want_reply.merge_found ||
              seen_reply.index_valid !== want_reply.index_valid) begin
            report($sformatf({"mismatch: expected elem %h len %0d found %b valid %b,",
                              " got elem %h len %0d found %b valid %b"},
                             want_reply.element_id, want_reply.corridor_length,
                             want_reply.merge_found, want_reply.index_valid,
                             seen_reply.element_id, seen_reply.corridor_length,
                             seen_reply.merge_found, seen_reply.index_valid));
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen_cmd.opcode     = cmd_if.opcode;
        seen_cmd.poly_id    = cmd_if.poly_id;
        seen_cmd.read_index = cmd_if.read_index;
        apply_command(seen_cmd, made_any, made_reply);
        if (made_any) begin
          reply_due.push_back(made_reply);
        end
        n_in <= n_in + 1;
      end
    end
    in_fire <= rst_ni && cmd_if.valid && cmd_if.ready;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and the end of the run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [pcm_pkg::ID_W-1:0] pool [6];
    logic [pcm_pkg::ID_W-1:0] fill_ids [CORR_N];
    int unsigned              pick;
    int unsigned              reps;
    bit                       fill_done;

    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.opcode      = '0;
    cmd_if.poly_id     = '0;
    cmd_if.read_index  = '0;
    rsp_if.ready       = 1'b0;
    in_fire            = 1'b0;
    n_cmds             = 0;
    n_in               = 0;
    n_fail             = 0;
    hold_left          = 0;
    hold_done          = 1'b0;
    corr_len           = 0;
    visit_len          = 0;
    fill_done          = 1'b0;

    // Directed part. Reads and a merge on an empty corridor first.
    add_cmd(pcm_pkg::OP_READ, '0, 8'd0);
    add_cmd(pcm_pkg::OP_READ, '0, 8'hFF);
    add_cmd(pcm_pkg::OP_MERGE, '0, '0);
    // Corridor with the extreme ids.
    add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, 32'h0000_0000, '0);
    add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, 32'hFFFF_FFFF, '0);
    add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, 32'h5A5A_5A5A, '0);
    add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, 32'hA5A5_A5A5, '0);
    // A merge without a common polygon leaves the corridor alone but still
    // empties the visited list.
    add_cmd(pcm_pkg::OP_PUSH_VISITED, 32'h1234_5678, '0);
    add_cmd(pcm_pkg::OP_MERGE, '0, '0);
    // The visited walk loops back through the same polygon: the earliest
    // visit of the join point wins, so all three ids become the new head.
    add_cmd(pcm_pkg::OP_PUSH_VISITED, 32'hFFFF_FFFF, '0);
    add_cmd(pcm_pkg::OP_PUSH_VISITED, 32'hCAFE_F00D, '0);
    add_cmd(pcm_pkg::OP_PUSH_VISITED, 32'hFFFF_FFFF, '0);
    add_cmd(pcm_pkg::OP_MERGE, '0, '0);
    for (int k = 0; k <= 5; k++) begin
      add_cmd(pcm_pkg::OP_READ, '0, pcm_pkg::IDX_W'(k));
    end
    // Spare opcodes must not produce a beat.
    add_cmd(OP_SPARE_A, 32'hFFFF_FFFF, 8'hFF);
    add_cmd(OP_SPARE_B, '0, '0);
    add_cmd(OP_SPARE_C, 32'h0F0F_0F0F, 8'h0F);
    // Clear keeps the visited list, so the next merge joins on a one-entry
    // corridor with an empty tail.
    add_cmd(pcm_pkg::OP_PUSH_VISITED, 32'd1, '0);
    add_cmd(pcm_pkg::OP_CLEAR, '0, '0);
    add_cmd(pcm_pkg::OP_READ, '0, 8'd0);
    add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, 32'd1, '0);
    add_cmd(pcm_pkg::OP_MERGE, '0, '0);
    add_cmd(pcm_pkg::OP_READ, '0, 8'd0);

    // Random part. Most of it is walk sequences drawn from a small pool of
    // ids, so merges find join points often.
    while (n_cmds < CMD_TARGET) begin
      pick = $urandom_range(99);
      if (!fill_done && (pick >= 92 || n_cmds > CMD_TARGET / 2)) begin
        // Fill the corridor past its depth, then merge with a full visited
        // list that joins near the front, so the tail gets truncated.
        fill_done = 1'b1;
        add_cmd(pcm_pkg::OP_CLEAR, '0, '0);
        for (int k = 0; k < int'(CORR_N); k++) begin
          fill_ids[k] = $urandom;
          add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, fill_ids[k], '0);
        end
        add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, $urandom, '0);
        add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, $urandom, '0);
        add_cmd(pcm_pkg::OP_READ, '0, 8'hFF);
        add_cmd(pcm_pkg::OP_READ, '0, 8'h00);
        add_cmd(pcm_pkg::OP_PUSH_VISITED, fill_ids[1], '0);
        for (int k = 0; k < int'(VISIT_N); k++) begin
          add_cmd(pcm_pkg::OP_PUSH_VISITED, $urandom, '0);
        end
        add_cmd(pcm_pkg::OP_MERGE, '0, '0);
        add_cmd(pcm_pkg::OP_READ, '0, 8'hFF);
        add_cmd(pcm_pkg::OP_READ, '0, pcm_pkg::IDX_W'(VISIT_N - 1));
        add_cmd(pcm_pkg::OP_READ, '0, pcm_pkg::IDX_W'(VISIT_N));
        add_cmd(pcm_pkg::OP_READ, '0, pcm_pkg::IDX_W'($urandom_range(255)));
        add_cmd(pcm_pkg::OP_CLEAR, '0, '0);
      end else if (pick < 70) begin
        for (int k = 0; k < 6; k++) begin
          pool[k] = $urandom;
        end
        if ($urandom_range(1) == 1) begin
          add_cmd(pcm_pkg::OP_CLEAR, '0, '0);
        end
        reps = $urandom_range(12, 1);
        for (int k = 0; k < int'(reps); k++) begin
          add_cmd(pcm_pkg::OP_PUSH_CORRIDOR,
                  ($urandom_range(4) == 0) ? $urandom : pool[$urandom_range(5)],
                  pcm_pkg::IDX_W'($urandom_range(255)));
        end
        reps = $urandom_range(6);
        for (int k = 0; k < int'(reps); k++) begin
          add_cmd(pcm_pkg::OP_PUSH_VISITED,
                  ($urandom_range(9) < 7) ? pool[$urandom_range(5)] : $urandom,
                  pcm_pkg::IDX_W'($urandom_range(255)));
        end
        add_cmd(pcm_pkg::OP_MERGE, $urandom, pcm_pkg::IDX_W'($urandom_range(255)));
        reps = $urandom_range(4, 1);
        for (int k = 0; k < int'(reps); k++) begin
          add_cmd(pcm_pkg::OP_READ, $urandom,
                  pcm_pkg::IDX_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                           : $urandom_range(20)));
        end
      end else if (pick < 80) begin
        // Noise: any opcode, any field values.
        reps = $urandom_range(6, 1);
        for (int k = 0; k < int'(reps); k++) begin
          add_cmd(pcm_pkg::OP_W'($urandom_range(7)), $urandom,
                  pcm_pkg::IDX_W'($urandom_range(255)));
        end
      end else if (pick < 88) begin
        // Overfill the visited list; the extra pushes are dropped.
        for (int k = 0; k < 6; k++) begin
          pool[k] = $urandom;
        end
        add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, pool[0], '0);
        add_cmd(pcm_pkg::OP_PUSH_CORRIDOR, pool[1], '0);
        reps = $urandom_range(VISIT_N + 3, VISIT_N + 1);
        for (int k = 0; k < int'(reps); k++) begin
          add_cmd(pcm_pkg::OP_PUSH_VISITED, pool[$urandom_range(5)], '0);
        end
        add_cmd(pcm_pkg::OP_MERGE, '0, '0);
        add_cmd(pcm_pkg::OP_READ, '0, pcm_pkg::IDX_W'($urandom_range(VISIT_N)));
      end else begin
        add_cmd(pcm_pkg::OP_CLEAR, $urandom, pcm_pkg::IDX_W'($urandom_range(255)));
        add_cmd(pcm_pkg::OP_READ, '0, pcm_pkg::IDX_W'($urandom_range(255)));
        add_cmd(pcm_pkg::OP_MERGE, '0, '0);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last command to go in and for every expected result.
    while (cmd_backlog.size() != 0 || cmd_if.valid) begin
      @(posedge clk_i);
    end
    while (reply_due.size() != 0) begin
      @(posedge clk_i);
    end
    // A trailing spare opcode or a stray beat would show up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (reply_due.size() != 0) begin
      report("expected result never arrived");
    end

    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/pcm_pkg.sv
src/pcm_if.sv
src/pcm_cell.sv
src/path_corridor_merge.sv
src/pcm_checker.sv
tb/sv/tb.sv
